FILE: rtl/affine_from_three_points_defines.svh
// assertion macros shared by the affine solver checks
`ifndef AFFINE_FROM_THREE_POINTS_DEFINES_SVH
`define AFFINE_FROM_THREE_POINTS_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define AFFTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("affine solver check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define AFFTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("affine solver check failed");

`endif

FILE: rtl/afftp_pkg.sv
// shared widths, types and constants of the affine solver
package afftp_pkg;

  localparam int CW       = 32;          // coordinate and coefficient width
  localparam int NLANE    = 6;           // coefficients per result
  localparam int DW       = 68;          // determinant magnitude width
  localparam int NW       = 104;         // signed numerator width
  localparam int QW       = 32;          // quotient bits formed per lane
  localparam int ITER     = QW;          // one quotient bit per stage
  localparam int LANE_LAT = ITER + 2;    // prep + steps + saturation
  localparam int IN_W     = 12 * CW;
  localparam int OUT_W    = NLANE * CW;

  localparam logic [CW-1:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [CW-1:0] COEF_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] COEF_MIN = 32'h8000_0000;

  // lane order on the output beat
  localparam int LANE_A    = 0;
  localparam int LANE_B    = 1;
  localparam int LANE_OFFX = 2;
  localparam int LANE_C    = 3;
  localparam int LANE_D    = 4;
  localparam int LANE_OFFY = 5;

  typedef logic signed [NW-1:0] num_t;
  typedef logic [DW-1:0]        mag_t;
  typedef logic [CW-1:0]        coef_t;

  typedef struct packed {
    logic vld;
    logic sing;
  } afftp_ctl_t;

endpackage

FILE: rtl/afftp_front.sv
// six-stage front end: differences, products, determinant and numerators
module afftp_front
  import afftp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [IN_W-1:0]  data_i,
  input  logic [CW-1:0]    thr_i,
  output num_t             num_o [NLANE],
  output mag_t             mag_o,
  output logic             dneg_o,
  output afftp_ctl_t       ctl_o
);

  typedef logic signed [32:0]  d33_t;
  typedef logic signed [63:0]  p64_t;
  typedef logic signed [64:0]  p65_t;
  typedef logic signed [66:0]  s67_t;
  typedef logic signed [96:0]  t97_t;
  typedef logic signed [DW-1:0] det_t;

  logic signed [CW-1:0] xin [3], yin [3], uin [3], vin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xin[i] = data_i[64*i      +: CW];
      yin[i] = data_i[64*i + 32 +: CW];
      uin[i] = data_i[192 + 64*i      +: CW];
      vin[i] = data_i[192 + 64*i + 32 +: CW];
    end
  end

  // stage 1: coordinate differences
  logic signed [CW-1:0] x1_q [3], y1_q [3], u1_q [3], v1_q [3];
  d33_t k1_q [3], l1_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= xin;
      y1_q <= yin;
      u1_q <= uin;
      v1_q <= vin;
      k1_q[0] <= d33_t'(yin[1]) - d33_t'(yin[2]);
      k1_q[1] <= d33_t'(yin[2]) - d33_t'(yin[0]);
      k1_q[2] <= d33_t'(yin[0]) - d33_t'(yin[1]);
      l1_q[0] <= d33_t'(xin[2]) - d33_t'(xin[1]);
      l1_q[1] <= d33_t'(xin[0]) - d33_t'(xin[2]);
      l1_q[2] <= d33_t'(xin[1]) - d33_t'(xin[0]);
    end
  end

  // stage 2: all single-width products
  p64_t pp2_q [3], pn2_q [3];
  p65_t dx2_q, dy2_q;
  p65_t ku2_q [3], lu2_q [3], kv2_q [3], lv2_q [3];
  logic signed [CW-1:0] u2_q [3], v2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp2_q[0] <= p64_t'(x1_q[1]) * p64_t'(y1_q[2]);
      pn2_q[0] <= p64_t'(x1_q[2]) * p64_t'(y1_q[1]);
      pp2_q[1] <= p64_t'(x1_q[2]) * p64_t'(y1_q[0]);
      pn2_q[1] <= p64_t'(x1_q[0]) * p64_t'(y1_q[2]);
      pp2_q[2] <= p64_t'(x1_q[0]) * p64_t'(y1_q[1]);
      pn2_q[2] <= p64_t'(x1_q[1]) * p64_t'(y1_q[0]);
      dx2_q <= p65_t'(x1_q[0]) * p65_t'(k1_q[0]);
      dy2_q <= p65_t'(y1_q[0]) * p65_t'(l1_q[0]);
      for (int i = 0; i < 3; i++) begin
        ku2_q[i] <= p65_t'(k1_q[i]) * p65_t'(u1_q[i]);
        lu2_q[i] <= p65_t'(l1_q[i]) * p65_t'(u1_q[i]);
        kv2_q[i] <= p65_t'(k1_q[i]) * p65_t'(v1_q[i]);
        lv2_q[i] <= p65_t'(l1_q[i]) * p65_t'(v1_q[i]);
      end
      u2_q <= u1_q;
      v2_q <= v1_q;
    end
  end

  // stage 3: cross terms, determinant, linear numerators
  p65_t m3_q [3];
  det_t det3_q;
  s67_t na3_q, nb3_q, nc3_q, nd3_q;
  logic signed [CW-1:0] u3_q [3], v3_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m3_q[i] <= p65_t'(pp2_q[i]) - p65_t'(pn2_q[i]);
      end
      det3_q <= det_t'(dx2_q) + det_t'(dy2_q) + det_t'(pp2_q[0]) - det_t'(pn2_q[0]);
      na3_q <= s67_t'(ku2_q[0]) + s67_t'(ku2_q[1]) + s67_t'(ku2_q[2]);
      nb3_q <= s67_t'(lu2_q[0]) + s67_t'(lu2_q[1]) + s67_t'(lu2_q[2]);
      nc3_q <= s67_t'(kv2_q[0]) + s67_t'(kv2_q[1]) + s67_t'(kv2_q[2]);
      nd3_q <= s67_t'(lv2_q[0]) + s67_t'(lv2_q[1]) + s67_t'(lv2_q[2]);
      u3_q <= u2_q;
      v3_q <= v2_q;
    end
  end

  // stage 4: split offset products, determinant magnitude
  p65_t mlu4_q [3], mhu4_q [3], mlv4_q [3], mhv4_q [3];
  mag_t mag4_q;
  logic dneg4_q;
  s67_t na4_q, nb4_q, nc4_q, nd4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mlu4_q[i] <= p65_t'(signed'({1'b0, m3_q[i][31:0]})) * p65_t'(u3_q[i]);
        mhu4_q[i] <= p65_t'(signed'(m3_q[i][64:32]))       * p65_t'(u3_q[i]);
        mlv4_q[i] <= p65_t'(signed'({1'b0, m3_q[i][31:0]})) * p65_t'(v3_q[i]);
        mhv4_q[i] <= p65_t'(signed'(m3_q[i][64:32]))       * p65_t'(v3_q[i]);
      end
      mag4_q  <= det3_q[DW-1] ? mag_t'(-det3_q) : mag_t'(det3_q);
      dneg4_q <= det3_q[DW-1];
      na4_q <= na3_q;
      nb4_q <= nb3_q;
      nc4_q <= nc3_q;
      nd4_q <= nd3_q;
    end
  end

  // stage 5: rejoin offset products, collinear test
  t97_t tu5_q [3], tv5_q [3];
  mag_t mag5_q;
  logic dneg5_q, sing5_q;
  s67_t na5_q, nb5_q, nc5_q, nd5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        tu5_q[i] <= (t97_t'(mhu4_q[i]) <<< 32) + t97_t'(mlu4_q[i]);
        tv5_q[i] <= (t97_t'(mhv4_q[i]) <<< 32) + t97_t'(mlv4_q[i]);
      end
      mag5_q  <= mag4_q;
      dneg5_q <= dneg4_q;
      sing5_q <= (mag4_q == '0) || (mag4_q < mag_t'(thr_i));
      na5_q <= na4_q;
      nb5_q <= nb4_q;
      nc5_q <= nc4_q;
      nd5_q <= nd4_q;
    end
  end

  // stage 6: offset sums, Q16.16 alignment of the linear numerators
  num_t num6_q [NLANE];
  mag_t mag6_q;
  logic dneg6_q, sing6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num6_q[LANE_A]    <= num_t'(na5_q) <<< 16;
      num6_q[LANE_B]    <= num_t'(nb5_q) <<< 16;
      num6_q[LANE_C]    <= num_t'(nc5_q) <<< 16;
      num6_q[LANE_D]    <= num_t'(nd5_q) <<< 16;
      num6_q[LANE_OFFX] <= num_t'(tu5_q[0]) + num_t'(tu5_q[1]) + num_t'(tu5_q[2]);
      num6_q[LANE_OFFY] <= num_t'(tv5_q[0]) + num_t'(tv5_q[1]) + num_t'(tv5_q[2]);
      mag6_q  <= mag5_q;
      dneg6_q <= dneg5_q;
      sing6_q <= sing5_q;
    end
  end

  // valid travels with the data
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  assign num_o    = num6_q;
  assign mag_o    = mag6_q;
  assign dneg_o   = dneg6_q;
  assign ctl_o.vld  = vld_q[5];
  assign ctl_o.sing = sing6_q;

endmodule

FILE: rtl/afftp_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage, saturating
module afftp_div_lane
  import afftp_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  num_t  num_i,
  input  mag_t  mag_i,
  input  logic  dneg_i,
  output coef_t quo_o,
  output logic  clip_o
);

  localparam int PAD = NW - DW - QW;

  num_t absn;
  logic big_c;

  always_comb begin
    absn  = num_i[NW-1] ? -num_i : num_i;
    big_c = unsigned'(absn) >= {{PAD{1'b0}}, mag_i, {QW{1'b0}}};
  end

  mag_t            rem_q [ITER+1];
  logic [QW-1:0]   wrd_q [ITER+1];
  mag_t            mag_q [ITER+1];
  logic [ITER:0]   neg_q, big_q;

  logic [DW:0]     trial [ITER], diff [ITER];
  logic [ITER-1:0] ge;

  always_comb begin
    for (int i = 0; i < ITER; i++) begin
      trial[i] = {rem_q[i], wrd_q[i][QW-1]};
      diff[i]  = trial[i] - {1'b0, mag_q[i]};
      ge[i]    = trial[i] >= {1'b0, mag_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= absn[DW+QW-1:QW];
      wrd_q[0] <= absn[QW-1:0];
      mag_q[0] <= mag_i;
      neg_q[0] <= num_i[NW-1] ^ dneg_i;
      big_q[0] <= big_c;
      for (int i = 0; i < ITER; i++) begin
        rem_q[i+1] <= ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
        wrd_q[i+1] <= {wrd_q[i][QW-2:0], ge[i]};
        mag_q[i+1] <= mag_q[i];
        neg_q[i+1] <= neg_q[i];
        big_q[i+1] <= big_q[i];
      end
    end
  end

  // sign and saturation
  logic [QW-1:0] q;
  logic          neg, sat_c;
  coef_t         val_c;

  always_comb begin
    q     = wrd_q[ITER];
    neg   = neg_q[ITER];
    sat_c = big_q[ITER] || (!neg && q[QW-1]) || (neg && (q > COEF_MIN));
    if (sat_c) begin
      val_c = neg ? COEF_MIN : COEF_MAX;
    end else begin
      val_c = neg ? coef_t'(-q) : coef_t'(q);
    end
  end

  coef_t quo_q;
  logic  clip_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q  <= val_c;
      clip_q <= sat_c;
    end
  end

  assign quo_o  = quo_q;
  assign clip_o = clip_q;

endmodule

FILE: rtl/affine_from_three_points.sv
// affine matrix from three point pairs: top level
//
// input beat: three source and three destination points, signed Q16.16,
//   packed in s_axis_tdata; output beat: the 2x3 matrix in m_axis_tdata,
//   singular and clipped flags in m_axis_tuser
// det_threshold is written through cfg_wr_en_i / cfg_wr_data_i while idle;
//   |det| below it (or det zero) gives the identity with singular set
// path from an accepted input beat to its output beat: 6 front stages,
//   a 34-stage divider lane per coefficient, then the output register
// throughput: one beat per cycle unless the output is held; each of the six
//   lanes forms one quotient bit per stage; an item enters every such cycle
// reset: clears all valid bits and sets det_threshold to 1
// stall: the whole pipeline holds while the output beat waits; up to 41
//   items sit in flight, and s_axis_tready drops only when the output is full
module affine_from_three_points
  import afftp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [CW-1:0]    cfg_wr_data_i,   // det_threshold
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // src_x0, src_y0, src_x1, src_y1, src_x2, src_y2,
  // dst_x0, dst_y0, dst_x1, dst_y1, dst_x2, dst_y2 (32 bit each)
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // coef_a, coef_b, offset_x, coef_c, coef_d, offset_y (32 bit each)
  output logic [OUT_W-1:0] m_axis_tdata,
  // singular, clipped
  output logic [1:0]       m_axis_tuser
);

  // threshold register
  logic [CW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= CW'(1);
    end else if (cfg_wr_en_i) begin
      thr_q <= cfg_wr_data_i;
    end
  end

  // global advance: move whenever the output slot is free or being taken
  logic en;
  logic m_vld_q;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // front end
  num_t       num [NLANE];
  mag_t       mag;
  logic       dneg;
  afftp_ctl_t front_ctl;

  afftp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .data_i (s_axis_tdata),
    .thr_i  (thr_q),
    .num_o  (num),
    .mag_o  (mag),
    .dneg_o (dneg),
    .ctl_o  (front_ctl)
  );

  // one divider lane per coefficient
  coef_t           quo  [NLANE];
  logic [NLANE-1:0] clip;

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    afftp_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num[g]),
      .mag_i  (mag),
      .dneg_i (dneg),
      .quo_o  (quo[g]),
      .clip_o (clip[g])
    );
  end

  // valid and collinear flag ride alongside the divider lanes
  afftp_ctl_t ctl_dly_q [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        ctl_dly_q[i] <= '0;
      end
    end else if (en) begin
      ctl_dly_q[0] <= front_ctl;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctl_dly_q[i] <= ctl_dly_q[i-1];
      end
    end
  end

  // output register: identity for collinear points
  coef_t out_q [NLANE];
  logic  sing_q, clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= ctl_dly_q[LANE_LAT-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= ctl_dly_q[LANE_LAT-1].sing;
      if (ctl_dly_q[LANE_LAT-1].sing) begin
        // ones on the diagonal, zeros elsewhere
        for (int i = 0; i < NLANE; i++) begin
          out_q[i] <= (i == LANE_A || i == LANE_D) ? ONE_Q16 : '0;
        end
        clip_q <= 1'b0;
      end else begin
        out_q  <= quo;
        clip_q <= |clip;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      m_axis_tdata[i*CW +: CW] = out_q[i];
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tuser  = {clip_q, sing_q};

endmodule

FILE: rtl/afftp_checker.sv
// port-level checks of the affine solver, bound to the top level
`include "affine_from_three_points_defines.svh"

module afftp_checker
  import afftp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [1:0]       m_axis_tuser
);

  // a held output beat keeps its payload
  `AFFTP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // input side stalls only while an output beat is held
  `AFFTP_ASSERT_NOW(a_stall, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // collinear result is the identity and never clipped
  `AFFTP_ASSERT_NOW(a_ident, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == ONE_Q16 && m_axis_tdata[159:128] == ONE_Q16 && m_axis_tdata[63:32] == '0 && m_axis_tdata[95:64] == '0 && m_axis_tdata[127:96] == '0 && m_axis_tdata[191:160] == '0 && !m_axis_tuser[1])

  // clipped means some coefficient sits at a range limit
  `AFFTP_ASSERT_NOW(a_clip, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[31:0] == COEF_MAX || m_axis_tdata[31:0] == COEF_MIN || m_axis_tdata[63:32] == COEF_MAX || m_axis_tdata[63:32] == COEF_MIN || m_axis_tdata[95:64] == COEF_MAX || m_axis_tdata[95:64] == COEF_MIN || m_axis_tdata[127:96] == COEF_MAX || m_axis_tdata[127:96] == COEF_MIN || m_axis_tdata[159:128] == COEF_MAX || m_axis_tdata[159:128] == COEF_MIN || m_axis_tdata[191:160] == COEF_MAX || m_axis_tdata[191:160] == COEF_MIN)

endmodule

bind affine_from_three_points afftp_checker u_afftp_checker (.*);
